>>> sv/pfe_pkg.sv
`timescale 1ns / 1ps
package pfe_pkg;

  localparam int DATA_W = 32;
  localparam int DIGIT_W = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_CNT_W = $clog2(DATA_W);

  localparam logic [7:0] SYM_ZERO  = 8'h30;
  localparam logic [7:0] SYM_NINE  = 8'h39;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_TIMES = 8'h2A;
  localparam logic [7:0] SYM_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_DROP
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [DIGIT_W-1:0]  digit;
    logic                last;
  } cmd_t;

endpackage

>>> sv/pfe_front.sv
`timescale 1ns / 1ps
module pfe_front
  import pfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_symbol,
  input  logic       in_last,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_take
);

  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] q_cnt_r, q_cnt_nxt;
  cmd_t              cls;
  logic              push;

  // classify the incoming character
  always_comb begin
    cls.digit = in_symbol[DIGIT_W-1:0];
    cls.last  = in_last;
    unique case (in_symbol) inside
      [SYM_ZERO:SYM_NINE]: cls.op = OP_PUSH;
      SYM_PLUS:            cls.op = OP_ADD;
      SYM_MINUS:           cls.op = OP_SUB;
      SYM_TIMES:           cls.op = OP_MUL;
      SYM_SLASH:           cls.op = OP_DIV;
      default:             cls.op = OP_DROP;
    endcase
  end

  assign in_stall  = (q_cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (q_cnt_r != '0);
  assign cmd       = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (cmd_take) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !cmd_take) begin
      q_cnt_nxt = q_cnt_r + 1'b1;
    end else if (!push && cmd_take) begin
      q_cnt_nxt = q_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
    if (push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> sv/pfe_div.sv
`timescale 1ns / 1ps
module pfe_div
  import pfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient,
  output logic              zero_div
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIX
  } dstate_t;

  dstate_t              state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic [DATA_W-1:0]    dq_r, dq_nxt;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    mb_r, mb_nxt;
  logic [DATA_W-1:0]    quot_r, quot_nxt;
  logic                 zero_r, zero_nxt;
  logic                 done_r, done_nxt;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      diff;
  logic [DATA_W-1:0]    ma, mb;

  assign ma     = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
  assign mb     = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
  assign rem_sh = {rem_r, dq_r[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, mb_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    mb_nxt    = mb_r;
    quot_nxt  = quot_r;
    zero_nxt  = zero_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          if (divisor == '0) begin
            quot_nxt = '0;
            zero_nxt = 1'b1;
            done_nxt = 1'b1;
          end else begin
            neg_nxt   = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            dq_nxt    = ma;
            mb_nxt    = mb;
            rem_nxt   = '0;
            cnt_nxt   = DIV_CNT_W'(DATA_W - 1);
            zero_nxt  = 1'b0;
            state_nxt = D_RUN;
          end
        end
      end
      D_RUN: begin
        if (!diff[DATA_W]) begin
          rem_nxt = diff[DATA_W-1:0];
          dq_nxt  = {dq_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DATA_W-1:0];
          dq_nxt  = {dq_r[DATA_W-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          state_nxt = D_FIX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      D_FIX: begin
        quot_nxt  = neg_r ? (DATA_W'(0) - dq_r) : dq_r;
        done_nxt  = 1'b1;
        state_nxt = D_IDLE;
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    mb_r   <= mb_nxt;
    quot_r <= quot_nxt;
    zero_r <= zero_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r;
  assign zero_div = zero_r;

endmodule

>>> sv/pfe_back.sv
`timescale 1ns / 1ps
module pfe_back
  import pfe_pkg::*;
#(
  parameter int STACK_DEPTH = 128
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmd_valid,
  input  cmd_t                     cmd,
  output logic                     cmd_take,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_divide_by_zero,
  output logic                     out_stack_overflow
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_R,
    S_POP_L,
    S_EXEC,
    S_DIV,
    S_PUSH,
    S_FIN_RD,
    S_FIN_OUT
  } state_t;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     dz_r, dz_nxt;
  logic                     ovf_r, ovf_nxt;
  op_t                      op_r, op_nxt;
  logic                     last_r, last_nxt;
  logic                     hit_r, hit_nxt;
  logic [DATA_W-1:0]        right_r, right_nxt;
  logic [DATA_W-1:0]        res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_dz_r, out_dz_nxt;
  logic                     out_ovf_r, out_ovf_nxt;

  logic [CW-1:0]     cnt_m1;
  logic [DATA_W-1:0] pop_val;
  logic              push_en, pop_en;
  logic [DATA_W-1:0] push_val;
  logic              mem_we, rd_en;
  logic [AW-1:0]     mem_wa, rd_addr;
  logic              div_start, div_done, div_zero;
  logic [DATA_W-1:0] div_quot;

  assign cnt_m1  = cnt_r - 1'b1;
  assign rd_addr = cnt_m1[AW-1:0];
  assign mem_wa  = cnt_r[AW-1:0];
  assign pop_val = hit_r ? rd_data_r : '1;

  pfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pop_val),
    .divisor  (right_r),
    .done     (div_done),
    .quotient (div_quot),
    .zero_div (div_zero)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    dz_nxt        = dz_r;
    ovf_nxt       = ovf_r;
    op_nxt        = op_r;
    last_nxt      = last_r;
    hit_nxt       = hit_r;
    right_nxt     = right_r;
    res_nxt       = res_r;
    out_value_nxt = out_value_r;
    out_dz_nxt    = out_dz_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd_take      = 1'b0;
    div_start     = 1'b0;
    push_en       = 1'b0;
    push_val      = res_r;
    pop_en        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          op_nxt   = cmd.op;
          last_nxt = cmd.last;
          if (cmd.op == OP_PUSH) begin
            push_en   = 1'b1;
            push_val  = DATA_W'(cmd.digit);
            state_nxt = cmd.last ? S_FIN_RD : S_IDLE;
          end else begin
            state_nxt = S_POP_R;
          end
        end
      end
      S_POP_R: begin
        pop_en    = 1'b1;
        state_nxt = S_POP_L;
      end
      S_POP_L: begin
        right_nxt = pop_val;
        pop_en    = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (op_r)
          OP_ADD: begin
            res_nxt   = pop_val + right_r;
            state_nxt = S_PUSH;
          end
          OP_SUB: begin
            res_nxt   = pop_val - right_r;
            state_nxt = S_PUSH;
          end
          OP_MUL: begin
            res_nxt   = pop_val * right_r;
            state_nxt = S_PUSH;
          end
          OP_DIV: begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
          default: state_nxt = last_r ? S_FIN_RD : S_IDLE;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt   = div_quot;
          dz_nxt    = dz_r | div_zero;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        push_en   = 1'b1;
        state_nxt = last_r ? S_FIN_RD : S_IDLE;
      end
      S_FIN_RD: begin
        pop_en    = 1'b1;
        state_nxt = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = pop_val;
          out_dz_nxt    = dz_r;
          out_ovf_nxt   = ovf_r;
          cnt_nxt       = '0;
          dz_nxt        = 1'b0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // stack pointer moves
    mem_we = 1'b0;
    rd_en  = pop_en;
    if (pop_en) begin
      hit_nxt = (cnt_r != '0);
      if (cnt_r != '0) begin
        cnt_nxt = cnt_m1;
      end
    end
    if (push_en) begin
      if (cnt_r == CW'(STACK_DEPTH)) begin
        ovf_nxt = 1'b1;
      end else begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= push_val;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      dz_r        <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dz_r        <= dz_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    last_r      <= last_nxt;
    hit_r       <= hit_nxt;
    right_r     <= right_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
    out_dz_r    <= out_dz_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_value          = out_value_r;
  assign out_divide_by_zero = out_dz_r;
  assign out_stack_overflow = out_ovf_r;

endmodule

>>> sv/postfix_expression_evaluator.sv
`timescale 1ns / 1ps
// Postfix evaluator, one ASCII character per request, in_last on the final one. The front
// end classifies each character and queues up to 4 requests, so input keeps flowing while
// the back end works. Back end per request: a digit is pushed; + - * make two stack reads
// from the operand memory, execute and push; / makes the same two reads, then waits for
// the one-bit-per-cycle divider and pushes its quotient. A last request adds
// the final pop and loads the output register, which holds the result while the next
// expression proceeds. Divide by zero pushes 0, a push on a full stack is dropped; both
// raise sticky flags reported with the result and then cleared.
module postfix_expression_evaluator
  import pfe_pkg::*;
#(
  parameter int STACK_DEPTH = 128
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_symbol,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_divide_by_zero,
  output logic                     out_stack_overflow
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  pfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_symbol (in_symbol),
    .in_last   (in_last),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  pfe_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd_valid),
    .cmd                (cmd),
    .cmd_take           (cmd_take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_value          (out_value),
    .out_divide_by_zero (out_divide_by_zero),
    .out_stack_overflow (out_stack_overflow)
  );

`ifndef ASSERT_OFF
  a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_valid)
    else $error("back end took from an empty queue");

  a_stall_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> cmd_valid)
    else $error("input stalled with nothing queued");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
